// ===== rtl/rbu_pkg.sv =====
// Shared types and constants for the raw Bayer byte unpacker.
`timescale 1ns / 1ps
`default_nettype none

package rbu_pkg;

  // Sample depth codes.
  typedef enum logic [1:0] {
    DEPTH_8  = 2'd0,
    DEPTH_10 = 2'd1,
    DEPTH_12 = 2'd2,
    DEPTH_16 = 2'd3
  } depth_t;

  // Packing codes; the fourth code behaves as CSI packed.
  typedef logic [1:0] pack_t;
  localparam pack_t PACK_CSI     = 2'd0;
  localparam pack_t PACK_COMPACT = 2'd1;
  localparam pack_t PACK_ALIGNED = 2'd2;

  // Register map.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_DEPTH   = 1'b0;
  localparam logic REG_PACKING = 1'b1;

  typedef struct packed {
    depth_t depth;
    pack_t  packing;
  } cfg_t;

  // One finished group: up to four pixels and the index of the last one.
  typedef struct packed {
    logic [3:0][7:0] px;
    logic [1:0]      last_idx;
  } grp_t;

endpackage

`default_nettype wire

// ===== rtl/rbu_cfg_regs.sv =====
// APB configuration registers: sample depth and packing.
`timescale 1ns / 1ps
`default_nettype none

module rbu_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rbu_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output rbu_pkg::cfg_t                      cfg
);
  import rbu_pkg::*;

  depth_t depth_r;
  pack_t  packing_r;
  logic   wr_en;
  logic   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= DEPTH_8;
      packing_r <= PACK_CSI;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DEPTH:   depth_r   <= depth_t'(pwdata[1:0]);
        REG_PACKING: packing_r <= pwdata[1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEPTH:   prdata = {30'd0, depth_r};
      REG_PACKING: prdata = {30'd0, packing_r};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg.depth   = depth_r;
  assign cfg.packing = packing_r;

endmodule

`default_nettype wire

// ===== rtl/rbu_group.sv =====
// Input register, group collection and bit unpacking of a closed group.
`timescale 1ns / 1ps
`default_nettype none

module rbu_group (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rbu_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_frame_start,
  output logic               grp_valid,
  input  wire logic          grp_ready,
  output rbu_pkg::grp_t      grp
);
  import rbu_pkg::*;

  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            s1_fs_r;
  logic [2:0]      count_r;
  logic [2:0]      count_eff;
  logic [2:0]      count_nxt;
  logic [2:0]      size;
  logic            closes;
  logic            go;
  logic [3:0][7:0] held_r;
  logic [7:0]      cur;
  logic [7:0]      b0, b1, b2, b3;

  assign cur = s1_byte_r;
  assign b0  = held_r[0];
  assign b1  = held_r[1];
  assign b2  = held_r[2];
  assign b3  = held_r[3];

  // Frame start realigns the grouping before this beat is counted.
  assign count_eff = s1_fs_r ? 3'd0 : count_r;

  always_comb begin
    unique case (cfg.depth)
      DEPTH_8:  size = 3'd1;
      DEPTH_10: size = (cfg.packing == PACK_ALIGNED) ? 3'd2 : 3'd5;
      DEPTH_12: size = (cfg.packing == PACK_ALIGNED) ? 3'd2 : 3'd3;
      DEPTH_16: size = 3'd2;
      default:  size = 3'd2;
    endcase
  end

  assign closes    = ({1'b0, count_eff} + 4'd1) >= {1'b0, size};
  assign go        = s1_valid_r && (!closes || grp_ready);
  assign in_stall  = s1_valid_r && !go;
  assign grp_valid = s1_valid_r && closes;
  assign count_nxt = closes ? 3'd0 : count_eff + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      count_r    <= 3'd0;
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (go)        count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_fs_r   <= in_frame_start;
    end
    if (go && !closes) held_r[count_eff[1:0]] <= cur;
  end

  // Unpack the closed group; held bytes start at index 0, cur is the last byte.
  always_comb begin
    grp.px       = '0;
    grp.last_idx = 2'd0;
    unique case (cfg.depth)
      DEPTH_10: begin
        case (cfg.packing)
          PACK_ALIGNED: grp.px[0] = {cur[1:0], b0[7:2]};
          PACK_COMPACT: begin
            grp.px[0]    = {b1[1:0], b0[7:2]};
            grp.px[1]    = {b2[3:0], b1[7:4]};
            grp.px[2]    = {b3[5:0], b2[7:6]};
            grp.px[3]    = cur;
            grp.last_idx = 2'd3;
          end
          default: begin
            grp.px       = {b3, b2, b1, b0};
            grp.last_idx = 2'd3;
          end
        endcase
      end
      DEPTH_12: begin
        case (cfg.packing)
          PACK_ALIGNED: grp.px[0] = {cur[3:0], b0[7:4]};
          PACK_COMPACT: begin
            grp.px[0]    = {b1[3:0], b0[7:4]};
            grp.px[1]    = cur;
            grp.last_idx = 2'd1;
          end
          default: begin
            grp.px[0]    = b0;
            grp.px[1]    = b1;
            grp.last_idx = 2'd1;
          end
        endcase
      end
      default: grp.px[0] = cur;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rbu_out_ser.sv =====
// Result register holding one group; drains its pixels one beat per cycle while out_stall is low.
`timescale 1ns / 1ps
`default_nettype none

module rbu_out_ser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          grp_valid,
  output logic               grp_ready,
  input  wire rbu_pkg::grp_t grp,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_pixel,
  output logic               out_last_of_group
);
  import rbu_pkg::*;

  logic            res_valid_r;
  logic [3:0][7:0] px_r;
  logic [1:0]      last_r;
  logic [1:0]      idx_r;
  logic            at_last;
  logic            take;

  assign at_last   = (idx_r == last_r);
  assign grp_ready = !res_valid_r || (!out_stall && at_last);
  assign take      = grp_valid && grp_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (take) begin
      res_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (res_valid_r && !out_stall) begin
      if (at_last) res_valid_r <= 1'b0;
      else         idx_r       <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      px_r   <= grp.px;
      last_r <= grp.last_idx;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_pixel         = px_r[idx_r];
  assign out_last_of_group = at_last;

endmodule

`default_nettype wire

// ===== rtl/raw_bayer_unpack_to_8bit.sv =====
// Top level of the raw Bayer byte unpacker to 8-bit pixels.
// Usage:
//  - Input channel: one packed raw byte per beat (in_data_byte) with
//    in_frame_start marking the first byte of a frame. A beat moves when
//    in_valid is high and in_stall is low.
//  - Output channel: one 8-bit pixel per beat; out_last_of_group flags the
//    final pixel produced by the closing byte of a group.
//  - APB port sets sample depth (byte 0) and packing (byte 4); write it only
//    while no beats are in flight.
// Path: input register, combinational unpack, result register to the output.
// Throughput: one byte per cycle unless stalled; groups of 5, 3, 2 or 1 bytes
// give 4, 2, 1 or 1 pixels, so the output pixel rate stays at or below the
// byte rate. The single result register sets the rate, draining one pixel per
// cycle unless out_stall is high.
// Reset: depth and packing go to 8-bit CSI, the group count clears, both
// pipeline stages empty; held bytes are not cleared.
// Stall: the result register holds its group; the input register keeps taking
// bytes that only add to the open group, and stalls once a byte closes one.
`timescale 1ns / 1ps
`default_nettype none

module raw_bayer_unpack_to_8bit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rbu_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // byte input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_frame_start,
  // pixel output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_pixel,
  output logic                               out_last_of_group
);
  import rbu_pkg::*;

  cfg_t cfg;
  grp_t grp;
  logic grp_valid;
  logic grp_ready;

  rbu_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Collect bytes and unpack the group when its last byte arrives.
  rbu_group u_group (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .grp_valid      (grp_valid),
    .grp_ready      (grp_ready),
    .grp            (grp)
  );

  // Hold the group and emit its pixels in order.
  rbu_out_ser u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .grp_valid         (grp_valid),
    .grp_ready         (grp_ready),
    .grp               (grp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel         (out_pixel),
    .out_last_of_group (out_last_of_group)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the raw Bayer byte unpacker with a pixel predictor.
`timescale 1ns / 1ps
module tb_top;
  import rbu_pkg::*;

  // Register byte addresses: each register sits on its own 32-bit word.
  localparam logic [CFG_ADDR_W-1:0] DEPTH_ADDR   = {REG_DEPTH, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] PACKING_ADDR = {REG_PACKING, 2'b00};

  // The fourth packing code has no name in the package; the block treats it as CSI.
  localparam pack_t PACK_CSI_ALT = 2'd3;

  localparam int IDLE_PCT      = 19;  // chance of a gap or stall per cycle
  localparam int SETTLE_CYCLES = 12;  // margin after the last owed pixel
  localparam int LONG_HOLD     = 80;  // long receiver hold-off, in cycles

  typedef struct packed {
    logic [7:0] data;
    logic       frame_start;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_frame_start;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_pixel;
  logic        out_last_of_group;

  // Bytes waiting to be driven, and pixels the block still owes us.
  raw_byte_t byte_q[$];
  pixel_t    pixel_q[$];

  // Predictor state: configuration copy, held bytes of the open group, group count.
  depth_t     cur_depth;
  pack_t      cur_pack;
  logic [7:0] held[4];
  logic [2:0] grp_count;

  int errors;
  int bytes_taken;
  int pixels_seen;
  int settings_used;

  bit calm;          // no gaps and no stalls while set
  bit hold_request;  // ask the receiver for one long hold-off
  bit in_fire;       // an input beat moved at the last rising edge
  int hold_left;

  raw_bayer_unpack_to_8bit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel         (out_pixel),
    .out_last_of_group (out_last_of_group)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Take one accepted byte into the group; when it closes the group, queue the
  // pixels it releases, the last one flagged.
  function automatic void unpack_byte(input logic [7:0] cur, input logic fs);
    logic [2:0]  need;
    logic [7:0]  px[4];
    logic [9:0]  s10;
    logic [11:0] s12;
    logic [15:0] word;
    pixel_t      p;
    int          n;
    int          k;
    px = '{default: 8'h00};
    n = 0;
    // Frame start realigns: drop whatever partial group was held.
    if (fs) grp_count = '0;
    case (cur_depth)
      DEPTH_8:  need = 3'd1;
      DEPTH_10: need = (cur_pack == PACK_ALIGNED) ? 3'd2 : 3'd5;
      DEPTH_12: need = (cur_pack == PACK_ALIGNED) ? 3'd2 : 3'd3;
      default:  need = 3'd2;
    endcase
    // Not the closing byte yet: hold it and give nothing. A count carried over
    // from a wider mode may already reach the new size, so the test is "<".
    if (grp_count + 3'd1 < need) begin
      held[grp_count[1:0]] = cur;
      grp_count = grp_count + 3'd1;
      return;
    end
    word = {cur, held[0]};
    case (cur_depth)
      DEPTH_10: begin
        if (cur_pack == PACK_ALIGNED) begin
          px[0] = word[9:2];
          n = 1;
        end else if (cur_pack == PACK_COMPACT) begin
          // Little-endian bit stream: four 10-bit samples back to back.
          s10 = {held[1][1:0], held[0]};
          px[0] = s10[9:2];
          s10 = {held[2][3:0], held[1][7:2]};
          px[1] = s10[9:2];
          s10 = {held[3][5:0], held[2][7:4]};
          px[2] = s10[9:2];
          s10 = {cur, held[3][7:6]};
          px[3] = s10[9:2];
          n = 4;
        end else begin
          // CSI: the four leading bytes are the pixels, drop the low-bit byte.
          px = held;
          n = 4;
        end
      end
      DEPTH_12: begin
        if (cur_pack == PACK_ALIGNED) begin
          px[0] = word[11:4];
          n = 1;
        end else if (cur_pack == PACK_COMPACT) begin
          s12 = {held[1][3:0], held[0]};
          px[0] = s12[11:4];
          s12 = {cur, held[1][7:4]};
          px[1] = s12[11:4];
          n = 2;
        end else begin
          px[0] = held[0];
          px[1] = held[1];
          n = 2;
        end
      end
      // 8-bit: the byte itself; 16-bit: the high byte closes the group.
      default: begin
        px[0] = cur;
        n = 1;
      end
    endcase
    grp_count = '0;
    for (k = 0; k < n; k++) begin
      p.pixel = px[k];
      p.last  = (k == n - 1);
      pixel_q.push_back(p);
    end
  endfunction

  // Monitor: sample both handshakes at the rising edge, before the block's
  // registers update, predict on input beats and check output beats.
  always @(posedge clk) begin
    pixel_t want;
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      unpack_byte(in_data_byte, in_frame_start);
      bytes_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: pixel with none expected: got %02h last %0b",
                 $time, out_pixel, out_last_of_group);
      end else begin
        want = pixel_q.pop_front();
        if (out_pixel !== want.pixel) begin
          errors++;
          $display("%0t: pixel mismatch: expected %02h, got %02h",
                   $time, want.pixel, out_pixel);
        end
        if (out_last_of_group !== want.last) begin
          errors++;
          $display("%0t: last_of_group mismatch: expected %0b, got %0b",
                   $time, want.last, out_last_of_group);
        end
      end
    end
  end

  // Driver: at the falling edge, advance to the next byte once the current beat
  // has moved (or none is offered); otherwise hold the payload steady.
  always @(negedge clk) begin
    raw_byte_t b;
    if (!in_valid || in_fire) begin
      if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        b = byte_q.pop_front();
        in_valid       <= 1'b1;
        in_data_byte   <= b.data;
        in_frame_start <= b.frame_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls: random, except in calm stretches, plus one long hold-off
  // counted here so the block backs up and stalls its input.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Wait until every byte has moved and every owed pixel has come out, then
  // give the block time to finish a byte that closed nothing.
  task automatic drain();
    while (byte_q.size() != 0 || in_valid || pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase register write: setup, then access until pready.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reconfigure only with the block idle; the group count is left alone, so a
  // partial group carries over into the new mode.
  task automatic set_mode(input depth_t depth, input pack_t packing);
    drain();
    cfg_write(DEPTH_ADDR, 32'(depth));
    cfg_write(PACKING_ADDR, 32'(packing));
    cur_depth = depth;
    cur_pack  = packing;
    settings_used++;
    @(posedge clk);
  endtask

  task automatic feed(input logic [7:0] data, input logic fs);
    raw_byte_t b;
    b.data = data;
    b.frame_start = fs;
    byte_q.push_back(b);
  endtask

  // Mostly a clean frame: frame start on the first byte, then plain bytes.
  // Now and then a messy one with stray frame starts that break groups.
  task automatic random_frame(input int len);
    bit messy;
    int i;
    messy = ($urandom_range(0, 99) < 20);
    for (i = 0; i < len; i++) begin
      if (i == 0)
        feed(8'($urandom), $urandom_range(0, 99) < 75);
      else
        feed(8'($urandom), messy && ($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    int j;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    in_data_byte   = 8'h00;
    in_frame_start = 1'b0;
    out_stall      = 1'b0;
    errors         = 0;
    bytes_taken    = 0;
    pixels_seen    = 0;
    settings_used  = 0;
    calm           = 1'b0;
    hold_request   = 1'b0;
    hold_left      = 0;
    held           = '{default: 8'h00};
    grp_count      = '0;
    cur_depth      = DEPTH_8;
    cur_pack       = PACK_CSI;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset mode is 8-bit; byte extremes with both frame-start values.
    feed(8'h00, 1'b1);
    feed(8'hFF, 1'b0);
    feed(8'h5A, 1'b0);
    // 10-bit CSI: four leading bytes out, low-bit byte dropped.
    set_mode(DEPTH_10, PACK_CSI);
    feed(8'hFF, 1'b1);
    feed(8'h00, 1'b0);
    feed(8'hA5, 1'b0);
    feed(8'h5A, 1'b0);
    feed(8'h3C, 1'b0);
    // 12-bit compact with extreme nibbles.
    set_mode(DEPTH_12, PACK_COMPACT);
    feed(8'hFF, 1'b1);
    feed(8'h0F, 1'b0);
    feed(8'hF0, 1'b0);
    // Incomplete 10-bit compact group, then switch to 12-bit aligned mid-group:
    // the next byte closes the group right away.
    set_mode(DEPTH_10, PACK_COMPACT);
    feed(8'h12, 1'b1);
    feed(8'h34, 1'b0);
    feed(8'h56, 1'b0);
    feed(8'h78, 1'b0);
    set_mode(DEPTH_12, PACK_ALIGNED);
    feed(8'h9A, 1'b0);
    // 16-bit with the fourth packing code; a frame start splits a pair.
    set_mode(DEPTH_16, PACK_CSI_ALT);
    feed(8'hFF, 1'b1);
    feed(8'h80, 1'b0);
    feed(8'h01, 1'b1);
    feed(8'h02, 1'b1);
    feed(8'h03, 1'b0);
    // 12-bit with the fourth packing code behaves as CSI.
    set_mode(DEPTH_12, PACK_CSI_ALT);
    feed(8'hAB, 1'b1);
    feed(8'hCD, 1'b0);
    feed(8'hEF, 1'b0);

    // Random: sweep every depth and packing code; the depth changes on every
    // step so partial groups keep crossing mode changes. One calm stretch.
    for (j = 0; j < 16; j++) begin
      set_mode(depth_t'(j % 4), pack_t'(j / 4));
      calm = (j >= 8 && j < 12);
      random_frame($urandom_range(3, 8));
    end

    // Back-pressure: 8-bit gives a pixel per byte, so a long hold fills the block.
    set_mode(DEPTH_8, PACK_CSI);
    hold_request = 1'b1;
    random_frame(30);

    repeat (4) begin
      set_mode(depth_t'($urandom_range(0, 3)), pack_t'($urandom_range(0, 3)));
      random_frame($urandom_range(4, 10));
    end

    drain();
    $display("Covered %0d bytes in %0d depth/packing settings, %0d pixels checked.",
             bytes_taken, settings_used, pixels_seen);
    $display("Included frame-start realignment, mid-group mode changes and a long stall.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
